### hdl/sd_read_ahead_policy_defines.svh
// ----------------------------------------------------------------------------
// sd_read_ahead_policy_defines
// Assertion macros shared by the read-ahead policy RTL.
// ----------------------------------------------------------------------------
`ifndef SD_READ_AHEAD_POLICY_DEFINES_SVH
`define SD_READ_AHEAD_POLICY_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define SDRA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define SDRA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sdra_pkg.sv
// ----------------------------------------------------------------------------
// sdra_pkg
// Codes and the result word type of the SD read-ahead policy.
// ----------------------------------------------------------------------------
package sdra_pkg;

  // request codes
  localparam logic [1:0] FUNC_READ   = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_INIT   = 2'd2;

  // data source codes
  localparam logic [1:0] SRC_CACHE  = 2'd0;
  localparam logic [1:0] SRC_STREAM = 2'd1;
  localparam logic [1:0] SRC_FRESH  = 2'd2;
  localparam logic [1:0] SRC_NONE   = 2'd3;

  // fetch command codes (CMD17 single block, CMD18 multi block)
  localparam logic [1:0] FCMD_NONE   = 2'd0;
  localparam logic [1:0] FCMD_SINGLE = 2'd1;
  localparam logic [1:0] FCMD_MULTI  = 2'd2;

  localparam int PORT_SECTOR_BITS = 32;

  typedef struct packed {
    logic                        status;
    logic [1:0]                  source;
    logic                        stop_issued;
    logic [1:0]                  fetch_cmd;
    logic                        prefetch_issued;
    logic [PORT_SECTOR_BITS-1:0] prefetch_sector;
  } sdra_res_t;

endpackage

### hdl/sdra_decide.sv
// ----------------------------------------------------------------------------
// sdra_decide
// Decision logic for one request: hit / stream / fetch, stop and prefetch,
// plus the next cache and stream state.
// ----------------------------------------------------------------------------
module sdra_decide import sdra_pkg::*; #(
  parameter int SECTOR_BITS = 32
) (
  input  logic [1:0]             func,
  input  logic [SECTOR_BITS-1:0] sector,
  input  logic [SECTOR_BITS-1:0] follow_sector,
  input  logic                   next_given,
  input  logic                   stop_ok,
  input  logic                   fetch_ok,
  input  logic                   prefetch_ok,
  input  logic [SECTOR_BITS-1:0] cached,
  input  logic [SECTOR_BITS-1:0] pending,
  input  logic                   active,
  output sdra_res_t              res,
  output logic [SECTOR_BITS-1:0] cached_next,
  output logic [SECTOR_BITS-1:0] pending_next,
  output logic                   active_next
);

  localparam logic [SECTOR_BITS-1:0] NO_SEC = '1;

  logic [SECTOR_BITS-1:0] succ;
  logic [SECTOR_BITS-1:0] nxt;

  assign succ = SECTOR_BITS'(sector + 1'b1);
  // all-ones next counts as not given
  assign nxt  = (!next_given || follow_sector == NO_SEC) ? succ : follow_sector;

  always_comb begin
    logic have;
    logic fail;
    logic multi;
    have         = 1'b0;
    fail         = 1'b0;
    multi        = 1'b0;
    res          = '0;
    res.source   = SRC_NONE;
    res.fetch_cmd = FCMD_NONE;
    cached_next  = cached;
    pending_next = pending;
    active_next  = active;
    unique case (func)
      FUNC_INIT: begin
        cached_next  = NO_SEC;
        pending_next = NO_SEC;
        active_next  = 1'b0;
      end
      FUNC_CANCEL: begin
        if (pending != NO_SEC) begin
          res.stop_issued = 1'b1;
          if (stop_ok) begin
            pending_next = NO_SEC;
            active_next  = 1'b0;
          end else begin
            res.status = 1'b1;
          end
        end
      end
      FUNC_READ: begin
        if (sector != NO_SEC && cached == sector) begin
          have       = 1'b1;
          res.source = SRC_CACHE;
        end else if (sector != NO_SEC && pending == sector) begin
          have         = 1'b1;
          res.source   = SRC_STREAM;
          cached_next  = sector;
          pending_next = active ? succ : NO_SEC;
        end
        // stream heads somewhere else: stop it
        if (pending_next != NO_SEC && nxt != pending_next) begin
          res.stop_issued = 1'b1;
          if (stop_ok) begin
            pending_next = NO_SEC;
            active_next  = 1'b0;
          end else begin
            res.status = 1'b1;
            fail       = 1'b1;
          end
        end
        if (!fail && !have) begin
          multi         = (nxt == succ);
          res.fetch_cmd = multi ? FCMD_MULTI : FCMD_SINGLE;
          if (fetch_ok) begin
            active_next  = active_next | multi;
            pending_next = active_next ? succ : NO_SEC;
            cached_next  = sector;
            res.source   = SRC_FRESH;
          end else begin
            res.status = 1'b1;
            fail       = 1'b1;
          end
        end
        if (!fail && pending_next == NO_SEC && nxt != NO_SEC) begin
          res.prefetch_issued = 1'b1;
          res.prefetch_sector = PORT_SECTOR_BITS'(nxt);
          if (prefetch_ok) begin
            pending_next = nxt;
            active_next  = 1'b1;
          end
        end
      end
      default: begin
        res.status = 1'b1;
      end
    endcase
  end

endmodule

### hdl/sd_read_ahead_policy.sv
// ----------------------------------------------------------------------------
// sd_read_ahead_policy
// Read-ahead decision logic of a one-sector SD card read cache (SPI mode).
// ----------------------------------------------------------------------------
// Each request is captured in an input register, decided in one pass of
// logic against the cached sector, the pending stream sector and the stream
// flag, and its result lands in an output register, from which the result
// word is offered on out_valid. The state updates as a request moves into the
// output register, which lets a request be accepted every cycle; the output
// register only backs up the input side when out_ready stays low.
// Sector numbers use the low SECTOR_BITS bits (up to 32) of the sector ports.
`include "sd_read_ahead_policy_defines.svh"

module sd_read_ahead_policy import sdra_pkg::*; #(
  parameter int SECTOR_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] sector,
  input  logic [31:0] follow_sector,
  input  logic        next_given,
  input  logic        stop_ok,
  input  logic        fetch_ok,
  input  logic        prefetch_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic [1:0]  source,
  output logic        stop_issued,
  output logic [1:0]  fetch_cmd,
  output logic        prefetch_issued,
  output logic [31:0] prefetch_sector
);

  localparam logic [SECTOR_BITS-1:0] NO_SEC = '1;

  // input register
  logic                   item_valid;
  logic [1:0]             item_func;
  logic [SECTOR_BITS-1:0] item_sector;
  logic [SECTOR_BITS-1:0] item_next;
  logic                   item_given;
  logic                   item_stop_ok;
  logic                   item_fetch_ok;
  logic                   item_pre_ok;

  // cache / stream state
  logic [SECTOR_BITS-1:0] cached_sector;
  logic [SECTOR_BITS-1:0] pending_sector;
  logic                   stream_active;
  logic [SECTOR_BITS-1:0] cached_sector_next;
  logic [SECTOR_BITS-1:0] pending_sector_next;
  logic                   stream_active_next;

  sdra_res_t res_next;
  sdra_res_t res;
  logic      advance;

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_func     <= func;
      item_sector   <= sector[SECTOR_BITS-1:0];
      item_next     <= follow_sector[SECTOR_BITS-1:0];
      item_given    <= next_given;
      item_stop_ok  <= stop_ok;
      item_fetch_ok <= fetch_ok;
      item_pre_ok   <= prefetch_ok;
    end
  end

  sdra_decide #(
    .SECTOR_BITS(SECTOR_BITS)
  ) u_decide (
    .func          (item_func),
    .sector        (item_sector),
    .follow_sector (item_next),
    .next_given    (item_given),
    .stop_ok       (item_stop_ok),
    .fetch_ok      (item_fetch_ok),
    .prefetch_ok   (item_pre_ok),
    .cached        (cached_sector),
    .pending       (pending_sector),
    .active        (stream_active),
    .res           (res_next),
    .cached_next   (cached_sector_next),
    .pending_next  (pending_sector_next),
    .active_next   (stream_active_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cached_sector  <= NO_SEC;
      pending_sector <= NO_SEC;
      stream_active  <= 1'b0;
    end else if (advance) begin
      cached_sector  <= cached_sector_next;
      pending_sector <= pending_sector_next;
      stream_active  <= stream_active_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign status          = res.status;
  assign source          = res.source;
  assign stop_issued     = res.stop_issued;
  assign fetch_cmd       = res.fetch_cmd;
  assign prefetch_issued = res.prefetch_issued;
  assign prefetch_sector = res.prefetch_sector;

  `SDRA_ASSERT_IMP(a_prefetch_no_error, out_valid && prefetch_issued, !status, "prefetch with error status")
  `SDRA_ASSERT_IMP(a_fetch_source, out_valid && fetch_cmd != FCMD_NONE, (source == SRC_FRESH) != status, "fetch result and source disagree")
  `SDRA_ASSERT_IMP(a_pending_needs_stream, !stream_active, pending_sector == NO_SEC, "sector pending without a stream")
  `SDRA_ASSERT_NXT(a_init_clears, advance && item_func == FUNC_INIT, cached_sector == NO_SEC && pending_sector == NO_SEC && !stream_active, "init left state behind")

endmodule

### verif/sd_read_ahead_policy_checker.sv
// ----------------------------------------------------------------------------
// sd_read_ahead_policy_checker
// Watches both channels of the read-ahead policy. Every accepted request word
// is run through a local model of the cache/stream decision. The predicted
// result is queued and compared field by field with the next result word.
// ----------------------------------------------------------------------------
module sd_read_ahead_policy_checker import sdra_pkg::*; #(
  parameter int SECTOR_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] sector,
  input  logic [31:0] follow_sector,
  input  logic        next_given,
  input  logic        stop_ok,
  input  logic        fetch_ok,
  input  logic        prefetch_ok,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        status,
  input  logic [1:0]  source,
  input  logic        stop_issued,
  input  logic [1:0]  fetch_cmd,
  input  logic        prefetch_issued,
  input  logic [31:0] prefetch_sector,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] SEC_MASK = 32'hFFFF_FFFF >> (32 - SECTOR_BITS);
  localparam logic [31:0] NO_SEC   = SEC_MASK;

  logic [31:0] cache_sec;
  logic [31:0] pend_sec;
  logic        streaming;
  sdra_res_t   expected_decisions[$];

  initial mismatches = 0;

  function automatic void clear_cache_state();
    cache_sec = NO_SEC;
    pend_sec  = NO_SEC;
    streaming = 1'b0;
  endfunction

  // card hands over the pending sector; a running stream moves on by one
  function automatic void deliver(input logic [31:0] sec);
    if (streaming)
      pend_sec = (pend_sec + 32'd1) & SEC_MASK;
    else
      pend_sec = NO_SEC;
    cache_sec = sec;
  endfunction

  function automatic sdra_res_t decide_read_ahead(
    input logic [1:0]  fn,
    input logic [31:0] sec_in,
    input logic [31:0] nxt_in,
    input logic        given,
    input logic        s_ok,
    input logic        f_ok,
    input logic        p_ok
  );
    sdra_res_t   r;
    logic [31:0] sec;
    logic [31:0] nxt;
    logic [31:0] succ;
    logic        have;
    logic        fail;
    r.status          = 1'b0;
    r.source          = SRC_NONE;
    r.stop_issued     = 1'b0;
    r.fetch_cmd       = FCMD_NONE;
    r.prefetch_issued = 1'b0;
    r.prefetch_sector = '0;
    sec  = sec_in & SEC_MASK;
    nxt  = nxt_in & SEC_MASK;
    succ = (sec + 32'd1) & SEC_MASK;
    have = 1'b0;
    fail = 1'b0;
    case (fn)
      FUNC_INIT: begin
        clear_cache_state();
      end
      FUNC_CANCEL: begin
        if (pend_sec != NO_SEC) begin
          r.stop_issued = 1'b1;
          if (s_ok) begin
            pend_sec  = NO_SEC;
            streaming = 1'b0;
          end else begin
            r.status = 1'b1;
          end
        end
      end
      FUNC_READ: begin
        if (!given || nxt == NO_SEC)
          nxt = succ;
        if (sec != NO_SEC && cache_sec == sec) begin
          have     = 1'b1;
          r.source = SRC_CACHE;
        end else if (sec != NO_SEC && pend_sec == sec) begin
          deliver(sec);
          have     = 1'b1;
          r.source = SRC_STREAM;
        end
        // stream heading somewhere else: stop it
        if (pend_sec != NO_SEC && nxt != pend_sec) begin
          r.stop_issued = 1'b1;
          if (s_ok) begin
            pend_sec  = NO_SEC;
            streaming = 1'b0;
          end else begin
            r.status = 1'b1;
            fail     = 1'b1;
          end
        end
        if (!fail && !have) begin
          if (nxt == succ) begin
            r.fetch_cmd = FCMD_MULTI;
            if (f_ok) begin
              pend_sec  = sec;
              streaming = 1'b1;
            end
          end else begin
            r.fetch_cmd = FCMD_SINGLE;
            if (f_ok)
              pend_sec = sec;
          end
          if (f_ok) begin
            deliver(sec);
            r.source = SRC_FRESH;
          end else begin
            r.status = 1'b1;
            fail     = 1'b1;
          end
        end
        if (!fail && pend_sec == NO_SEC && nxt != NO_SEC) begin
          r.prefetch_issued = 1'b1;
          r.prefetch_sector = nxt;
          if (p_ok) begin
            pend_sec  = nxt;
            streaming = 1'b1;
          end
        end
      end
      default: begin
        r.status = 1'b1;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    sdra_res_t want;
    if (rst) begin
      clear_cache_state();
      expected_decisions.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_decisions.size() == 0) begin
          $error("result word with no request outstanding");
          mismatches++;
        end else begin
          want = expected_decisions.pop_front();
          check_field("status", want.status, status);
          check_field("source", want.source, source);
          check_field("stop_issued", want.stop_issued, stop_issued);
          check_field("fetch_cmd", want.fetch_cmd, fetch_cmd);
          check_field("prefetch_issued", want.prefetch_issued, prefetch_issued);
          check_field("prefetch_sector", want.prefetch_sector, prefetch_sector);
        end
      end
      if (in_valid && in_ready)
        expected_decisions.push_back(decide_read_ahead(func, sector, follow_sector,
          next_given, stop_ok, fetch_ok, prefetch_ok));
    end
    outstanding <= expected_decisions.size();
  end

endmodule

### verif/tb_sd_read_ahead_policy.sv
// ----------------------------------------------------------------------------
// tb_sd_read_ahead_policy
// Drives read, cancel and init requests into the read-ahead policy: a directed
// opening, then mostly sequential read streams with random jumps, card
// failures and housekeeping requests. Both sides idle at random; the checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_sd_read_ahead_policy;
  import sdra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_WORDS = 1600;
  localparam int          IDLE_LIMIT   = 2000;
  localparam logic [31:0] TOP_SEC      = 32'hFFFF_FFFE;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] sector;
    logic [31:0] follow_sector;
    logic        next_given;
    logic        stop_ok;
    logic        fetch_ok;
    logic        prefetch_ok;
  } req_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  func;
  logic [31:0] sector;
  logic [31:0] follow_sector;
  logic        next_given;
  logic        stop_ok;
  logic        fetch_ok;
  logic        prefetch_ok;
  logic        out_valid;
  logic        out_ready;
  logic        status;
  logic [1:0]  source;
  logic        stop_issued;
  logic [1:0]  fetch_cmd;
  logic        prefetch_issued;
  logic [31:0] prefetch_sector;
  int          mismatches;
  int          outstanding;

  int          words_sent;
  int          results_taken;
  int          idle_cycles;
  logic [31:0] cur_sec;

  sd_read_ahead_policy i_dut (
    .clk, .rst, .in_valid, .in_ready, .func, .sector, .follow_sector, .next_given,
    .stop_ok, .fetch_ok, .prefetch_ok, .out_valid, .out_ready, .status, .source,
    .stop_issued, .fetch_cmd, .prefetch_issued, .prefetch_sector
  );

  sd_read_ahead_policy_checker i_checker (
    .clk, .rst, .in_valid, .in_ready, .func, .sector, .follow_sector, .next_given,
    .stop_ok, .fetch_ok, .prefetch_ok, .out_valid, .out_ready, .status, .source,
    .stop_issued, .fetch_cmd, .prefetch_issued, .prefetch_sector,
    .mismatches, .outstanding
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic req_t mk(input logic [1:0] fn, input logic [31:0] sec,
                              input logic [31:0] nxt, input logic given,
                              input logic s_ok, input logic f_ok, input logic p_ok);
    req_t w;
    w.func          = fn;
    w.sector        = sec;
    w.follow_sector = nxt;
    w.next_given    = given;
    w.stop_ok       = s_ok;
    w.fetch_ok      = f_ok;
    w.prefetch_ok   = p_ok;
    return w;
  endfunction

  function automatic logic [31:0] any_sec();
    return $urandom_range(TOP_SEC, 0);
  endfunction

  function automatic logic card_ok();
    return $urandom_range(99) < 88;
  endfunction

  // mostly a running stream of reads, with jumps, repeats and housekeeping
  function automatic req_t random_req();
    req_t        w;
    int          pick;
    logic [31:0] sec;
    logic [31:0] nxt;
    logic        given;
    pick = $urandom_range(99);
    if (pick < 5)
      return mk(FUNC_CANCEL, any_sec(), any_sec(), 1'($urandom_range(1)), card_ok(),
                card_ok(), card_ok());
    if (pick < 7)
      return mk(FUNC_INIT, any_sec(), any_sec(), 1'($urandom_range(1)), card_ok(),
                card_ok(), card_ok());
    pick = $urandom_range(99);
    if (pick < 55)
      sec = (cur_sec == TOP_SEC) ? 32'd0 : cur_sec + 32'd1;
    else if (pick < 70)
      sec = cur_sec;
    else if (pick < 80)
      sec = $urandom_range(TOP_SEC, TOP_SEC - 32'd6);
    else if (pick < 90)
      sec = $urandom_range(15);
    else
      sec = any_sec();
    given = 1'($urandom_range(1));
    if (given && sec != TOP_SEC && $urandom_range(99) < 70)
      nxt = sec + 32'd1;
    else if ($urandom_range(1))
      nxt = $urandom_range(15);
    else
      nxt = any_sec();
    cur_sec = sec;
    w = mk(FUNC_READ, sec, nxt, given, card_ok(), card_ok(), card_ok());
    return w;
  endfunction

  task automatic send_word(input req_t w);
    int gap;
    // every fifth stretch of 60 words goes back to back
    gap = ((words_sent / 60) % 5 == 4) ? 0 : $urandom_range(10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    func          <= w.func;
    sector        <= w.sector;
    follow_sector <= w.follow_sector;
    next_given    <= w.next_given;
    stop_ok       <= w.stop_ok;
    fetch_ok      <= w.fetch_ok;
    prefetch_ok   <= w.prefetch_ok;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
  endtask

  // result side: random stalls, one long hold-off, and stall-free stretches
  initial begin
    int stall;
    out_ready = 1'b0;
    results_taken = 0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (results_taken == 200)
        stall = 150;
      else if ((results_taken / 50) % 4 == 3)
        stall = 0;
      else
        stall = $urandom_range(10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_taken++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    func          = FUNC_READ;
    sector        = '0;
    follow_sector = '0;
    next_given    = 1'b0;
    stop_ok       = 1'b0;
    fetch_ok      = 1'b0;
    prefetch_ok   = 1'b0;
    words_sent    = 0;
    cur_sec       = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // stream start, cache hit, stream hit
    send_word(mk(FUNC_READ, 32'd5, 32'd0, 1'b0, 1'b1, 1'b1, 1'b1));
    send_word(mk(FUNC_READ, 32'd5, 32'd0, 1'b0, 1'b1, 1'b1, 1'b1));
    send_word(mk(FUNC_READ, 32'd6, 32'd7, 1'b1, 1'b1, 1'b1, 1'b1));
    // jump away: card refuses the stop, then accepts; single-block fetch
    send_word(mk(FUNC_READ, 32'd100, 32'd200, 1'b1, 1'b0, 1'b1, 1'b1));
    send_word(mk(FUNC_READ, 32'd100, 32'd200, 1'b1, 1'b1, 1'b1, 1'b1));
    // cancel: refused, accepted, nothing left to stop
    send_word(mk(FUNC_CANCEL, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1, 1'b1));
    send_word(mk(FUNC_CANCEL, TOP_SEC, TOP_SEC, 1'b1, 1'b1, 1'b1, 1'b1));
    send_word(mk(FUNC_CANCEL, 32'd0, 32'd0, 1'b0, 1'b1, 1'b1, 1'b1));
    // fetch refused, then a multi-block fetch
    send_word(mk(FUNC_READ, 32'd300, 32'd0, 1'b0, 1'b1, 1'b0, 1'b1));
    send_word(mk(FUNC_READ, 32'd300, 32'd301, 1'b1, 1'b1, 1'b1, 1'b1));
    send_word(mk(FUNC_INIT, TOP_SEC, TOP_SEC, 1'b1, 1'b0, 1'b0, 1'b0));
    // prefetch refused
    send_word(mk(FUNC_READ, 32'd400, 32'd500, 1'b1, 1'b1, 1'b1, 1'b0));
    send_word(mk(FUNC_READ, 32'd0, TOP_SEC, 1'b1, 1'b1, 1'b1, 1'b1));
    // stream runs off the top of the sector range
    send_word(mk(FUNC_READ, TOP_SEC - 32'd1, 32'd0, 1'b0, 1'b1, 1'b1, 1'b1));
    send_word(mk(FUNC_READ, TOP_SEC, 32'd0, 1'b0, 1'b1, 1'b1, 1'b1));
    send_word(mk(FUNC_READ, TOP_SEC, 32'h5555_5555, 1'b0, 1'b1, 1'b1, 1'b1));
    send_word(mk(FUNC_READ, 32'h0000_FFFF, 32'hAAAA_AAAA, 1'b1, 1'b1, 1'b1, 1'b1));
    send_word(mk(FUNC_READ, 32'd0, 32'd1, 1'b1, 1'b0, 1'b0, 1'b0));
    send_word(mk(FUNC_INIT, 32'd0, 32'd0, 1'b0, 1'b1, 1'b1, 1'b1));

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) begin
        in_valid <= 1'b0;
        wait_drained();
      end
      send_word(random_req());
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
